/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check clocked on clk_i, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same check, also evaluated while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

/* sv/ams_pkg.sv */
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types and constants for the affine matrix stack.
// ----------------------------------------------------------------------------
package ams_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned MatWords      = 6;
  localparam int unsigned LevelW        = 5;

  typedef enum logic [2:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_LOAD_ID = 3'd2,
    ACT_LOAD_M  = 3'd3,
    ACT_MUL     = 3'd4,
    ACT_MUL_LOC = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch operand and action
    logic execute;   // update top, write the saved store
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic ready;     // always-ready hook kept at one
  } stat_t;

endpackage

/* sv/ams_ctrl.sv */
// ----------------------------------------------------------------------------
// ams_ctrl
// Sequencer: capture, execute, present result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ams_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ams_pkg::stat_t stat_i,
  output ams_pkg::ctrl_t ctrl_o,
  output logic           busy_o,
  output logic           done_o
);

  ams_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ams_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctrl_o.capture = 1'b0;
    ctrl_o.execute = 1'b0;
    busy_o         = 1'b1;
    done_o         = 1'b0;
    case (state_q)
      ams_pkg::S_IDLE: begin
        busy_o         = 1'b0;
        ctrl_o.capture = start_i;
        if (start_i) state_d = ams_pkg::S_EXEC;
      end
      ams_pkg::S_EXEC: begin
        ctrl_o.execute = stat_i.ready;
        if (stat_i.ready) state_d = ams_pkg::S_DONE;
      end
      ams_pkg::S_DONE: begin
        done_o  = 1'b1;
        state_d = ams_pkg::S_IDLE;
      end
      default: state_d = ams_pkg::S_IDLE;
    endcase
  end

  `ASSERT_CLK(a_done_after_exec, done_o |-> $past(ctrl_o.execute), "done without execute")
  `ASSERT_CLK(a_exec_after_cap, ctrl_o.execute |-> $past(ctrl_o.capture), "execute w/o capture")
  `ASSERT_ALWAYS(a_idle_reset, !rst_ni |-> !busy_o, "busy in reset")

endmodule

/* sv/ams_datapath.sv */
// ----------------------------------------------------------------------------
// ams_datapath
// Top matrix register, saved-matrix store, fixed-point compose unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ams_datapath #(
  parameter int unsigned STACK_DEPTH = ams_pkg::StackDepthDef,
  parameter int unsigned FRAC_BITS   = ams_pkg::FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ams_pkg::ctrl_t       ctrl_i,
  output ams_pkg::stat_t       stat_o,
  input  logic [2:0]           action_i,
  input  logic signed [31:0]   in_m11_i,
  input  logic signed [31:0]   in_m12_i,
  input  logic signed [31:0]   in_m21_i,
  input  logic signed [31:0]   in_m22_i,
  input  logic signed [31:0]   in_dx_i,
  input  logic signed [31:0]   in_dy_i,
  output logic signed [31:0]   top_m11_o,
  output logic signed [31:0]   top_m12_o,
  output logic signed [31:0]   top_m21_o,
  output logic signed [31:0]   top_m22_o,
  output logic signed [31:0]   top_dx_o,
  output logic signed [31:0]   top_dy_o,
  output logic [1:0]           status_o,
  output logic [4:0]           level_o
);

  localparam int unsigned SavedN = STACK_DEPTH - 1;
  localparam int unsigned AddrW  = (SavedN > 1) ? $clog2(SavedN) : 1;
  localparam int unsigned CntW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MW     = ams_pkg::MatWords;
  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  logic [2:0]            act_q;
  logic signed [31:0]    op_q  [MW];
  logic signed [31:0]    top_q [MW];
  logic [CntW-1:0]       cnt_q;
  logic [1:0]            status_q;
  logic [32*MW-1:0]      saved_mem [SavedN];

  // Products: one multiplier per term, computed combinationally from top and
  // the operand; compose stays in execute.
  logic signed [63:0]    prod [12];
  logic signed [31:0]    a [MW];
  logic signed [31:0]    b [MW];
  logic signed [65:0]    sum [MW];
  logic signed [31:0]    res [MW];
  logic                  sat;
  logic                  is_loc;

  assign stat_o.ready = 1'b1;
  assign is_loc = (act_q == ams_pkg::ACT_MUL_LOC);

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      a[i] = is_loc ? op_q[i] : top_q[i];
      b[i] = is_loc ? top_q[i] : op_q[i];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 2; c++) begin
        prod[4*r+2*c]   = 64'(a[2*r]) * 64'(b[c]);
        prod[4*r+2*c+1] = 64'(a[2*r+1]) * 64'(b[2+c]);
      end
    end
    sat = 1'b0;
    for (int k = 0; k < MW; k++) begin
      sum[k] = 66'(prod[2*k] >>> FRAC_BITS) + 66'(prod[2*k+1] >>> FRAC_BITS)
             + ((k >= 4) ? 66'(b[k]) : 66'sd0);
      if (sum[k] > 66'sd2147483647) begin
        res[k] = 32'sh7fffffff; sat = 1'b1;
      end else if (sum[k] < -66'sd2147483648) begin
        res[k] = 32'sh80000000; sat = 1'b1;
      end else begin
        res[k] = sum[k][31:0];
      end
    end
  end

  logic [AddrW-1:0] wr_addr, rd_addr;
  assign wr_addr = AddrW'(cnt_q - 1'b1);
  assign rd_addr = AddrW'(cnt_q - 2'd2);

  // Entry below the top, fetched at capture so pop has it in execute.
  logic [32*MW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      act_q    <= action_i;
      op_q[0]  <= in_m11_i;
      op_q[1]  <= in_m12_i;
      op_q[2]  <= in_m21_i;
      op_q[3]  <= in_m22_i;
      op_q[4]  <= in_dx_i;
      op_q[5]  <= in_dy_i;
      rd_q     <= saved_mem[rd_addr];
    end
    if (ctrl_i.execute && act_q == ams_pkg::ACT_PUSH && cnt_q < CntW'(STACK_DEPTH)) begin
      saved_mem[wr_addr] <= {top_q[5], top_q[4], top_q[3], top_q[2], top_q[1], top_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q[0] <= One; top_q[1] <= '0; top_q[2] <= '0;
      top_q[3] <= One; top_q[4] <= '0; top_q[5] <= '0;
      cnt_q    <= CntW'(1);
      status_q <= ams_pkg::ST_OK;
    end else if (ctrl_i.execute) begin
      status_q <= ams_pkg::ST_OK;
      case (act_q)
        ams_pkg::ACT_PUSH: begin
          if (cnt_q < CntW'(STACK_DEPTH)) cnt_q <= cnt_q + 1'b1;
          else status_q <= ams_pkg::ST_OVERFLOW;
        end
        ams_pkg::ACT_POP: begin
          if (cnt_q > CntW'(1)) begin
            cnt_q <= cnt_q - 1'b1;
            for (int i = 0; i < MW; i++) top_q[i] <= rd_q[32*i +: 32];
          end else begin
            status_q <= ams_pkg::ST_UNDERFLOW;
          end
        end
        ams_pkg::ACT_LOAD_ID: begin
          top_q[0] <= One; top_q[1] <= '0; top_q[2] <= '0;
          top_q[3] <= One; top_q[4] <= '0; top_q[5] <= '0;
        end
        ams_pkg::ACT_LOAD_M: begin
          for (int i = 0; i < MW; i++) top_q[i] <= op_q[i];
        end
        ams_pkg::ACT_MUL, ams_pkg::ACT_MUL_LOC: begin
          for (int i = 0; i < MW; i++) top_q[i] <= res[i];
          if (sat) status_q <= ams_pkg::ST_SATURATED;
        end
        default: ;
      endcase
    end
  end

  assign top_m11_o = top_q[0];
  assign top_m12_o = top_q[1];
  assign top_m21_o = top_q[2];
  assign top_m22_o = top_q[3];
  assign top_dx_o  = top_q[4];
  assign top_dy_o  = top_q[5];
  assign status_o  = status_q;
  assign level_o   = 5'(cnt_q);

  `ASSERT_CLK(a_cnt_range, cnt_q >= CntW'(1) && cnt_q <= CntW'(STACK_DEPTH), "level range")
  `ASSERT_CLK(a_ovf_full, status_q == ams_pkg::ST_OVERFLOW |-> cnt_q == CntW'(STACK_DEPTH), "ovf")
  `ASSERT_CLK(a_unf_one, status_q == ams_pkg::ST_UNDERFLOW |-> cnt_q == CntW'(1), "underflow")

endmodule

/* sv/affine_matrix_stack_unit.sv */
// ----------------------------------------------------------------------------
// affine_matrix_stack_unit
// Stack of 2D affine transforms in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Drive action_i and the six operand ports with start high while busy
//   is low; that edge is the input transfer. busy then rises.
//   The result (top matrix, status_o, level_o) is shown for exactly one cycle
//   with done_o high, once the execute step has registered it. The
//   receiver cannot stall; it must take the result in that cycle.
//   The sequencer runs the capture, execute and result steps in order; busy
//   stays high through execute and result, so a new item is taken only
//   once the previous one is through.
//   The compose unit (twelve 32x32 products and saturating sums) sits in the
//   execute step; the saved entry below the top is read at capture.
//   Reset: top is identity, level is 1, block idle; the saved store needs no
//   clearing since pop only reads entries that a push wrote.
//   STACK_DEPTH sets the saved store to STACK_DEPTH-1 entries of six words;
//   FRAC_BITS sets the fixed-point scaling.
// ----------------------------------------------------------------------------
module affine_matrix_stack_unit #(
  parameter int unsigned STACK_DEPTH = ams_pkg::StackDepthDef,
  parameter int unsigned FRAC_BITS   = ams_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] in_m11_i,
  input  logic signed [31:0] in_m12_i,
  input  logic signed [31:0] in_m21_i,
  input  logic signed [31:0] in_m22_i,
  input  logic signed [31:0] in_dx_i,
  input  logic signed [31:0] in_dy_i,
  output logic signed [31:0] top_m11_o,
  output logic signed [31:0] top_m12_o,
  output logic signed [31:0] top_m21_o,
  output logic signed [31:0] top_m22_o,
  output logic signed [31:0] top_dx_o,
  output logic signed [31:0] top_dy_o,
  output logic [1:0]         status_o,
  output logic [4:0]         level_o
);

  ams_pkg::ctrl_t ctrl;
  ams_pkg::stat_t stat;

  ams_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy),
    .done_o (done_o)
  );

  ams_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .action_i (action_i),
    .in_m11_i (in_m11_i),
    .in_m12_i (in_m12_i),
    .in_m21_i (in_m21_i),
    .in_m22_i (in_m22_i),
    .in_dx_i  (in_dx_i),
    .in_dy_i  (in_dy_i),
    .top_m11_o(top_m11_o),
    .top_m12_o(top_m12_o),
    .top_m21_o(top_m21_o),
    .top_m22_o(top_m22_o),
    .top_dx_o (top_dx_o),
    .top_dy_o (top_dy_o),
    .status_o (status_o),
    .level_o  (level_o)
  );

endmodule

/* bench/tb_affine_matrix_stack_unit.sv */
// ----------------------------------------------------------------------------
// tb_affine_matrix_stack_unit
// Self-checking bench for the affine matrix stack: directed stack and
// arithmetic cases, then random command streams under varying sender gaps.
// ----------------------------------------------------------------------------
module tb_affine_matrix_stack_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;
  localparam int Frac  = 16;
  localparam logic signed [31:0] One = 32'sh0001_0000;

  typedef logic signed [31:0] mat_t [6];
  typedef struct {
    mat_t       top;
    logic [1:0] st;
    logic [4:0] lvl;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done_o;
  logic [2:0] action_i = '0;
  logic signed [31:0] in_m11_i = '0, in_m12_i = '0, in_m21_i = '0;
  logic signed [31:0] in_m22_i = '0, in_dx_i = '0, in_dy_i = '0;
  logic signed [31:0] top_m11_o, top_m12_o, top_m21_o, top_m22_o, top_dx_o, top_dy_o;
  logic [1:0] status_o;
  logic [4:0] level_o;

  affine_matrix_stack_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the stack
  mat_t       cur_top;
  mat_t       saved [Depth-1];
  int         depth_cnt;
  answer_t    pending_q [$];
  int         err_cnt;
  int         idle_pct;

  function automatic logic signed [63:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> Frac;  // floor
  endfunction

  function automatic logic signed [31:0] clamp(logic signed [65:0] v, ref logic sat);
    if (v > 66'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -66'sh8000_0000) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic void compose(input mat_t a, input mat_t b, output mat_t r, ref logic sat);
    r[0] = clamp(66'(fx_mul(a[0], b[0])) + fx_mul(a[1], b[2]), sat);
    r[1] = clamp(66'(fx_mul(a[0], b[1])) + fx_mul(a[1], b[3]), sat);
    r[2] = clamp(66'(fx_mul(a[2], b[0])) + fx_mul(a[3], b[2]), sat);
    r[3] = clamp(66'(fx_mul(a[2], b[1])) + fx_mul(a[3], b[3]), sat);
    r[4] = clamp(66'(fx_mul(a[4], b[0])) + fx_mul(a[5], b[2]) + b[4], sat);
    r[5] = clamp(66'(fx_mul(a[4], b[1])) + fx_mul(a[5], b[3]) + b[5], sat);
  endfunction

  function automatic answer_t predict_top(logic [2:0] act, mat_t m);
    answer_t a;
    mat_t r;
    logic sat;
    sat = 1'b0;
    a.st = ams_pkg::ST_OK;
    case (act)
      ams_pkg::ACT_PUSH: begin
        if (depth_cnt < Depth) begin
          saved[depth_cnt-1] = cur_top;
          depth_cnt++;
        end else a.st = ams_pkg::ST_OVERFLOW;
      end
      ams_pkg::ACT_POP: begin
        if (depth_cnt > 1) begin
          depth_cnt--;
          cur_top = saved[depth_cnt-1];
        end else a.st = ams_pkg::ST_UNDERFLOW;
      end
      ams_pkg::ACT_LOAD_ID: cur_top = '{One, 0, 0, One, 0, 0};
      ams_pkg::ACT_LOAD_M:  cur_top = m;
      ams_pkg::ACT_MUL: begin
        compose(cur_top, m, r, sat);
        cur_top = r;
      end
      ams_pkg::ACT_MUL_LOC: begin
        compose(m, cur_top, r, sat);
        cur_top = r;
      end
      default: ;
    endcase
    if (sat) a.st = ams_pkg::ST_SATURATED;
    a.top = cur_top;
    a.lvl = 5'(depth_cnt);
    return a;
  endfunction

  // start stays high after a transfer until the next item or an idle cycle
  task automatic send_cmd(logic [2:0] act, mat_t m);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    action_i <= act;
    in_m11_i <= m[0]; in_m12_i <= m[1]; in_m21_i <= m[2];
    in_m22_i <= m[3]; in_dx_i <= m[4]; in_dy_i <= m[5];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_q = {pending_q, predict_top(act, m)};
  endtask

  // result checker
  always @(posedge clk_i) begin
    answer_t e;
    mat_t got;
    if (rst_ni && done_o) begin
      got = '{top_m11_o, top_m12_o, top_m21_o, top_m22_o, top_dx_o, top_dy_o};
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = pending_q.pop_front();
        if (got != e.top || status_o != e.st || level_o != e.lvl) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp %p st %0d lvl %0d / got %p st %0d lvl %0d",
                     e.top, e.st, e.lvl, got, status_o, level_o);
        end
      end
    end
  end

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
      2: return ($urandom_range(1) ? One : -One);
      3: return ($urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
      default: return $signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000;
    endcase
  endfunction

  function automatic mat_t rnd_mat();
    mat_t m;
    foreach (m[i]) m[i] = rnd_word();
    return m;
  endfunction

  task automatic test_stack_limits();
    mat_t z;
    z = '{default: 0};
    send_cmd(ams_pkg::ACT_POP, z);                 // underflow on one entry
    send_cmd(ams_pkg::ACT_LOAD_M,
             '{32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1, 32'sh1234_5678, -5});
    for (int i = 0; i < Depth; i++) send_cmd(ams_pkg::ACT_PUSH, z);  // last one overflows
    send_cmd(3'd6, rnd_mat());
    send_cmd(3'd7, rnd_mat());
    for (int i = 0; i < Depth; i++) send_cmd(ams_pkg::ACT_POP, z);
  endtask

  task automatic test_arith();
    send_cmd(ams_pkg::ACT_LOAD_ID, rnd_mat());
    send_cmd(ams_pkg::ACT_MUL, '{2*One, -One, One/2, 3*One, -7, 9});
    send_cmd(ams_pkg::ACT_MUL_LOC, '{-1, 1, One, -One, 32'sh7FFF_FFFF, 32'sh8000_0000});
    send_cmd(ams_pkg::ACT_MUL, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
    send_cmd(ams_pkg::ACT_LOAD_M, '{-3, 5, -1, 1, 0, 0});
    send_cmd(ams_pkg::ACT_MUL_LOC, '{-1, -1, -1, -1, -1, -1});  // floor of negatives
  endtask

  task automatic test_random(int n);
    logic [2:0] act;
    for (int i = 0; i < n; i++) begin
      act = $urandom_range(99) < 4 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
      if (act == ams_pkg::ACT_LOAD_ID && $urandom_range(1)) act = ams_pkg::ACT_LOAD_M;
      send_cmd(act, rnd_mat());
    end
  endtask

  initial begin
    err_cnt = 0;
    idle_pct = 33;
    depth_cnt = 1;
    cur_top = '{One, 0, 0, One, 0, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_stack_limits();
    test_arith();
    test_random(180);
    idle_pct = 60;
    test_random(180);
    idle_pct = 0;
    test_random(180);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
